// ===== hw/rtl/unique_value_set_table_macros.svh =====
// assertion macros for the set table checker
`ifndef UNIQUE_VALUE_SET_TABLE_MACROS_SVH
`define UNIQUE_VALUE_SET_TABLE_MACROS_SVH

// property that holds in the same cycle
`define UVST_ASSERT_NOW(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("set table check failed");

// property whose consequent holds in the cycle after the trigger
`define UVST_ASSERT_NEXT(label, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("set table check failed");

`endif

// ===== hw/rtl/uvst_pkg.sv =====
`timescale 1ns / 1ps

package uvst_pkg;

    localparam int CAPACITY = 16;
    localparam int VALUE_W  = 32;
    localparam int CMD_W    = 2;
    localparam int COUNT_W  = 5;
    localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam logic [CMD_W-1:0] CMD_FIND   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ADD    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;

endpackage

// ===== hw/rtl/uvst_ram.sv =====
`timescale 1ns / 1ps

module uvst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                         clk,
    input  logic                                         we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                             wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                             rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hw/rtl/unique_value_set_table.sv =====
`timescale 1ns / 1ps
// channel   signals                                       handshake
// command   start, command, value                         start && !busy
// result    done, was_present, changed, full_refused,     done, one cycle
//           count, is_empty
//
// find and add: search from position 0 up to a hit or the last entry; delete:
// searching then moving each later entry down, all through the single read
// port of the entry ram
// busy covers the cycles between acceptance and the strobe cycle, in which the
// next item can already be taken
// reset clears the count, not the entry ram; the result shows for one cycle
// and the receiver cannot stall it

module unique_value_set_table (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [uvst_pkg::CMD_W-1:0]    command,
    input  logic signed [uvst_pkg::VALUE_W-1:0] value,
    output logic                          done,
    output logic                          was_present,
    output logic                          changed,
    output logic                          full_refused,
    output logic [uvst_pkg::COUNT_W-1:0]  count,
    output logic                          is_empty
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SEARCH = 4'b0010,
        ST_SHIFT  = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic [uvst_pkg::CNT_W-1:0]   count_reg, count_next;
    logic [uvst_pkg::CNT_W-1:0]   idx_reg, idx_next;
    logic                         present_reg, present_next;
    logic [uvst_pkg::CMD_W-1:0]   cmd_reg, cmd_next;
    logic [uvst_pkg::VALUE_W-1:0] value_reg, value_next;
    logic                         done_reg, done_next;
    logic                         was_present_reg, changed_reg, full_refused_reg;
    logic                         changed_next, full_refused_next;
    logic [uvst_pkg::CNT_W-1:0]   count_out_reg;

    logic [uvst_pkg::CNT_W-1:0]   idx_plus1, idx_plus2;
    logic                         ram_we;
    logic [uvst_pkg::ADDR_W-1:0]  ram_waddr, ram_raddr;
    logic [uvst_pkg::VALUE_W-1:0] ram_wdata, ram_rdata;

    uvst_ram #(
        .WIDTH(uvst_pkg::VALUE_W),
        .DEPTH(uvst_pkg::CAPACITY)
    ) u_entries (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign idx_plus1 = idx_reg + uvst_pkg::CNT_W'(1);
    assign idx_plus2 = idx_reg + uvst_pkg::CNT_W'(2);

    always_comb
    begin
        state_next        = state_reg;
        count_next        = count_reg;
        idx_next          = idx_reg;
        present_next      = present_reg;
        cmd_next          = cmd_reg;
        value_next        = value_reg;
        done_next         = 1'b0;
        changed_next      = 1'b0;
        full_refused_next = 1'b0;
        ram_we            = 1'b0;
        ram_waddr         = idx_reg[uvst_pkg::ADDR_W-1:0];
        ram_wdata         = ram_rdata;
        ram_raddr         = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd_next     = command;
                    value_next   = value;
                    idx_next     = '0;
                    present_next = 1'b0;
                    if (count_reg == '0)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        state_next = ST_SEARCH;
                    end
                end
            end
            ST_SEARCH:
            begin
                ram_raddr = idx_plus1[uvst_pkg::ADDR_W-1:0];
                if (ram_rdata == value_reg)
                begin
                    present_next = 1'b1;
                    if (cmd_reg == uvst_pkg::CMD_DELETE && idx_plus1 != count_reg)
                    begin
                        state_next = ST_SHIFT;
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                    end
                end
                else if (idx_plus1 == count_reg)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    idx_next = idx_plus1;
                end
            end
            ST_SHIFT:
            begin
                // move entry idx + 1 down to idx, fetch the one after it
                ram_raddr = idx_plus2[uvst_pkg::ADDR_W-1:0];
                ram_we    = 1'b1;
                if (idx_plus2 == count_reg)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    idx_next = idx_plus1;
                end
            end
            ST_FINISH:
            begin
                done_next  = 1'b1;
                state_next = ST_IDLE;
                case (cmd_reg)
                    uvst_pkg::CMD_ADD:
                    begin
                        if (!present_reg)
                        begin
                            if (count_reg != uvst_pkg::CNT_W'(uvst_pkg::CAPACITY))
                            begin
                                ram_we       = 1'b1;
                                ram_waddr    = count_reg[uvst_pkg::ADDR_W-1:0];
                                ram_wdata    = value_reg;
                                count_next   = count_reg + uvst_pkg::CNT_W'(1);
                                changed_next = 1'b1;
                            end
                            else
                            begin
                                full_refused_next = 1'b1;
                            end
                        end
                    end
                    uvst_pkg::CMD_DELETE:
                    begin
                        if (present_reg)
                        begin
                            count_next   = count_reg - uvst_pkg::CNT_W'(1);
                            changed_next = 1'b1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg     <= idx_next;
        present_reg <= present_next;
        cmd_reg     <= cmd_next;
        value_reg   <= value_next;
        if (state_reg == ST_FINISH)
        begin
            was_present_reg  <= present_reg;
            changed_reg      <= changed_next;
            full_refused_reg <= full_refused_next;
            count_out_reg    <= count_next;
        end
    end

    assign busy         = (state_reg != ST_IDLE);
    assign done         = done_reg;
    assign was_present  = was_present_reg;
    assign changed      = changed_reg;
    assign full_refused = full_refused_reg;
    assign count        = uvst_pkg::COUNT_W'(count_out_reg);
    assign is_empty     = (count_out_reg == '0);

endmodule

// ===== hw/rtl/uvst_check.sv =====
`timescale 1ns / 1ps
`include "unique_value_set_table_macros.svh"

module uvst_check (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 start,
    input logic                                 busy,
    input logic [uvst_pkg::CMD_W-1:0]           command,
    input logic signed [uvst_pkg::VALUE_W-1:0]  value,
    input logic                                 done,
    input logic                                 was_present,
    input logic                                 changed,
    input logic                                 full_refused,
    input logic [uvst_pkg::COUNT_W-1:0]         count,
    input logic                                 is_empty
);

    logic at_cap;

    assign at_cap = (count == uvst_pkg::COUNT_W'(uvst_pkg::CAPACITY));

    // an accepted item keeps the block busy until its result
    `UVST_ASSERT_NEXT(a_accept_busy, start && !busy, busy)

    // the result strobe comes only once the block is free again
    `UVST_ASSERT_NOW(a_done_idle, !done || !busy)

    // a refused add never changes the set and only happens at capacity
    `UVST_ASSERT_NOW(a_refused, !(done && full_refused) || (!changed && !was_present && at_cap))

    // the empty flag agrees with the count
    `UVST_ASSERT_NOW(a_empty, !done || (is_empty == (count == '0)))

endmodule

bind unique_value_set_table uvst_check u_check (.*);
